// ===== src/salwc_pkg.sv =====
// Shared types and constants of the LRU write-back cache tag controller.
`timescale 1ns / 1ps
`default_nettype none
package salwc_pkg;
	localparam logic [1:0] REG_WORD_BYTES  = 2'd0;
	localparam logic [1:0] REG_BLOCK_WORDS = 2'd1;
	localparam logic [1:0] REG_HIT_CYC     = 2'd2;
	localparam logic [1:0] REG_READ_CYC    = 2'd3;
	localparam logic [2:0] REG_WRITE_CYC   = 3'd4;
	localparam int COST_W = 20;
	localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;

	typedef struct packed {
		logic [1:0] word_bytes_log2;
		logic [2:0] block_words_log2;
		logic [7:0] hit_cycles;
		logic [7:0] read_block_cycles;
		logic [7:0] write_block_cycles;
	} cfg_t;

	// Saturating add of an 8-bit charge onto a running cost.
	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [7:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {{(COST_W-7){1'b0}}, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== src/salwc_cfg.sv =====
// Configuration register file of the cache tag controller.
`timescale 1ns / 1ps
`default_nettype none
module salwc_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output salwc_pkg::cfg_t        cfg
);
	salwc_pkg::cfg_t cfg_q;

	// Registers are written by index; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.word_bytes_log2    <= 2'd2;
			cfg_q.block_words_log2   <= 3'd2;
			cfg_q.hit_cycles         <= 8'd1;
			cfg_q.read_block_cycles  <= 8'd10;
			cfg_q.write_block_cycles <= 8'd10;
		end else if (cfg_we) begin
			if (cfg_index == {1'b0, salwc_pkg::REG_WORD_BYTES})
				cfg_q.word_bytes_log2 <= cfg_data[1:0];
			if (cfg_index == {1'b0, salwc_pkg::REG_BLOCK_WORDS})
				cfg_q.block_words_log2 <= cfg_data[2:0];
			if (cfg_index == {1'b0, salwc_pkg::REG_HIT_CYC})
				cfg_q.hit_cycles <= cfg_data;
			if (cfg_index == {1'b0, salwc_pkg::REG_READ_CYC})
				cfg_q.read_block_cycles <= cfg_data;
			if (cfg_index == salwc_pkg::REG_WRITE_CYC)
				cfg_q.write_block_cycles <= cfg_data;
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ===== src/set_assoc_lru_writeback_cache_tags.sv =====
// Top level: sequencer, line store and shared compare unit of the cache tags.
// Lookup: the scan reads one way per step and compares each entry from the registered read,
// then an update state writes the line and the result is offered; the next accept follows it.
// Flush: one line per cycle over SETS*WAYS lines, then the result is offered.
// A result stalled by m_tready holds s_tready low. After reset a clearing pass
// empties the line store first. Configuration resets to defaults.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_writeback_cache_tags #(
	parameter int SETS = 64,
	parameter int WAYS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // kind[1:0], byte_address[33:2], use_stamp[65:34]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,  // hit, line_dirty, way_used[2], cost_cycles[20],
	                                   // writeback_valid, writeback_block[32],
	                                   // fill_valid, fill_block[32], zero fill
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	localparam int LINES = SETS * WAYS;
	localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int SB = $clog2(SETS);
	localparam int TW = 32 - SB;
	// Entry: valid, dirty, tag, stamp.
	localparam int EW = 2 + TW + 32;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_UPD   = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	salwc_pkg::cfg_t cfg;
	salwc_cfg u_cfg (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

	logic [EW-1:0] mem [LINES];
	logic [EW-1:0] rd_q;
	logic [2:0]    state_q;
	logic [LW:0]   cnt_q;       // scan / sweep counter
	logic          rd_ok_q;     // rd_q holds the entry of the previous address
	logic [LW-1:0] rd_line_q;
	logic [WW-1:0] rd_way_q;    // way of the entry in rd_q during a scan
	logic          is_write_q;
	logic [31:0]   block_q, stamp_q;
	logic          dirty_q, found_q;
	logic [WW-1:0] way_q, vict_q;
	logic [31:0]   best_q;
	logic [TW-1:0] vtag_q;
	logic          vvalid_q, vdirty_q;
	logic [salwc_pkg::COST_W-1:0] cost_q;
	logic [89:0]   out_q;

	logic [31:0]   addr_in, block_in;
	logic [SW-1:0] set_q;
	logic [TW-1:0] tag_q;
	logic          we;
	logic [LW-1:0] waddr, raddr;
	logic [EW-1:0] wdata;
	logic          e_v, e_d;
	logic [TW-1:0] e_tag;
	logic [31:0]   e_stamp;

	assign addr_in = s_tdata[33:2];
	assign block_in = (addr_in >> cfg.word_bytes_log2) >> cfg.block_words_log2;
	assign e_v = rd_q[EW-1];
	assign e_d = rd_q[EW-2];
	assign e_tag = rd_q[EW-3 -: TW];
	assign e_stamp = rd_q[31:0];
	assign set_q = (SETS > 1) ? SW'(block_q[SB > 0 ? SB-1 : 0:0]) : '0;
	assign tag_q = block_q[31 -: TW];
	assign s_tready = (state_q == ST_IDLE);

	// Address of the line under scan: set base plus way counter in a lookup, the sweep counter in a flush.
	always_comb begin
		if (state_q == ST_FLUSH)
			raddr = cnt_q[LW-1:0];
		else
			raddr = LW'(set_q * WAYS) + LW'(cnt_q[WW-1:0]);
	end

	// Line store with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
		rd_line_q <= raddr;
		rd_way_q <= cnt_q[WW-1:0];
	end

	// Write data for clear, flush, and access update.
	always_comb begin
		we = 1'b0;
		waddr = raddr;
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			waddr = cnt_q[LW-1:0];
		end else if (state_q == ST_FLUSH && rd_ok_q && e_v && e_d) begin
			we = 1'b1;
			waddr = rd_line_q;
			wdata = {1'b1, 1'b0, e_tag, e_stamp};
		end else if (state_q == ST_UPD) begin
			we = 1'b1;
			waddr = LW'(set_q * WAYS) + LW'(found_q ? way_q : vict_q);
			wdata = {1'b1, is_write_q | (found_q & dirty_q), tag_q, stamp_q};
		end
	end

	// Sequencer with shared compare over the ways of one set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			rd_ok_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (LW+1)'(LINES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					cnt_q <= '0;
					rd_ok_q <= 1'b0;
					if (s_tvalid) begin
						state_q <= s_tdata[1] ? ST_FLUSH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_ok_q <= 1'b1;
					if (cnt_q < (LW+1)'(WAYS - 1)) cnt_q <= cnt_q + 1'b1;
					if (rd_ok_q && rd_way_q == WW'(WAYS - 1))
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_OUT;
					m_tvalid <= 1'b1;
				end
				ST_FLUSH: begin
					rd_ok_q <= 1'b1;
					if (cnt_q < (LW+1)'(LINES)) cnt_q <= cnt_q + 1'b1;
					if (rd_ok_q && rd_line_q == LW'(LINES - 1)) begin
						state_q <= ST_OUT;
						m_tvalid <= 1'b1;
					end
				end
				ST_OUT: begin
					if (m_tvalid && m_tready) begin
						m_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: capture, hit/LRU compare, cost and result packing.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			is_write_q <= (s_tdata[1:0] == 2'd1);
			block_q <= block_in;
			stamp_q <= s_tdata[65:34];
			found_q <= 1'b0;
			best_q <= '1;
			vict_q <= '0;
			cost_q <= s_tdata[1] ? '0 : {12'd0, cfg.hit_cycles};
		end
		if (state_q == ST_SCAN && rd_ok_q) begin
			if (!found_q && e_v && e_tag == tag_q) begin
				found_q <= 1'b1;
				way_q <= rd_way_q;
				dirty_q <= e_d;
			end
			// Way zero seeds the victim; later ways replace it only with a smaller stamp.
			if (rd_way_q == '0 || e_stamp < best_q) begin
				best_q <= e_stamp;
				vict_q <= rd_way_q;
				vtag_q <= e_tag;
				vvalid_q <= e_v;
				vdirty_q <= e_d;
			end
		end
		if (state_q == ST_FLUSH && rd_ok_q && e_v && e_d)
			cost_q <= salwc_pkg::sat_add(cost_q, cfg.write_block_cycles);
		if (state_q == ST_FLUSH)
			out_q <= '0;
		if (state_q == ST_UPD) begin
			logic wbv;
			logic [salwc_pkg::COST_W-1:0] c;
			wbv = !found_q && vvalid_q && vdirty_q;
			c = wbv ? salwc_pkg::sat_add(cost_q, cfg.write_block_cycles) : cost_q;
			if (!found_q) c = salwc_pkg::sat_add(c, cfg.read_block_cycles);
			out_q[0] <= found_q;
			out_q[1] <= found_q ? dirty_q : wbv;
			out_q[3:2] <= 2'(found_q ? way_q : vict_q);
			out_q[23:4] <= found_q ? cost_q : c;
			out_q[24] <= wbv;
			out_q[56:25] <= wbv ? (32'(vtag_q) << SB) | 32'(set_q) : 32'd0;
			out_q[57] <= !found_q;
			out_q[89:58] <= found_q ? 32'd0 : block_q;
		end
	end

	// A flush result is all zero except its cost, which comes from the running total.
	always_comb begin
		m_tdata = {6'd0, out_q};
		if (state_q == ST_OUT && out_q[57:0] == '0)
			m_tdata[23:4] = cost_q;
	end

	// The input side is never ready while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid));
	// A stalled result holds its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	// The sequencer stays within its defined states.
	assert property (@(posedge clk) disable iff (!arst_n) state_q <= ST_OUT);
	// No transaction is accepted during the clearing pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_tready);
endmodule
`default_nettype wire
